FILE: rtl/yuyv_to_nv12_chroma_average_assert.svh
// Assertion macros shared by the YUYV to NV12 chroma averaging block.
`ifndef YUYV_TO_NV12_CHROMA_AVERAGE_ASSERT_SVH
`define YUYV_TO_NV12_CHROMA_AVERAGE_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define Y2N_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("y2n check failed: same-cycle implication");

// Condition a implies condition b in the next cycle.
`define Y2N_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("y2n check failed: next-cycle implication");

`endif

FILE: rtl/y2n_pkg.sv
// Types and constants of the YUYV to NV12 chroma averaging block.
`default_nettype none
package y2n_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   localparam int PAIRS_W    = 10;
   localparam int LINES_W    = 13;
   localparam int SAMPLE_W   = 8;
   localparam int COLUMN_W   = 9;
   localparam int ROW_W      = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PAIRS_W-1:0] PAIRS_RESET = 10'd160;
   localparam logic [LINES_W-1:0] LINES_RESET = 13'd240;

   // Register index, taken from address bit 2 (registers lie 4 bytes apart).
   typedef enum logic {
      REG_PAIRS = 1'b0,
      REG_LINES = 1'b1
   } reg_index_type;

   // Position tag of one pixel pair, handed from the counters to the output stage.
   typedef struct packed {
      logic [COLUMN_W-1:0] pair_column;
      logic [ROW_W-1:0]    row_index;
      logic                chroma_valid;
      logic                frame_last;
   } tag_type;

endpackage
`default_nettype wire

FILE: rtl/y2n_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module y2n_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: rtl/y2n_position.sv
// Column and row counters with frame wrap and the line buffer slot of each pair.
`default_nettype none
module y2n_position #(
   parameter int LINE_DEPTH = 512,
   parameter int MAX_HEIGHT = 4096,
   localparam int COL_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
   localparam int CNT_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          frame_start,
   input  wire logic [y2n_pkg::PAIRS_W-1:0]   pairs_cfg,
   input  wire logic [y2n_pkg::LINES_W-1:0]   lines_cfg,
   output logic      [COL_W-1:0]              slot,
   output y2n_pkg::tag_type                   tag
);

   localparam int PW = (COL_W + 1 > y2n_pkg::PAIRS_W) ? COL_W + 1 : y2n_pkg::PAIRS_W;
   localparam int LW = (CNT_W + 1 > y2n_pkg::LINES_W) ? CNT_W + 1 : y2n_pkg::LINES_W;

   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [CNT_W-1:0] row_ff, row_in, row_cur;
   logic [PW-1:0]    pairs_eff, col_next;
   logic [LW-1:0]    lines_eff, row_next;
   logic             col_wrap, row_wrap;

   always_comb begin
      // Out-of-range sizes are clamped to the buffer and frame limits.
      pairs_eff = PW'(pairs_cfg);
      if (pairs_eff == '0) begin
         pairs_eff = PW'(1);
      end else if (pairs_eff > PW'(LINE_DEPTH)) begin
         pairs_eff = PW'(LINE_DEPTH);
      end
      lines_eff = LW'(lines_cfg);
      if (lines_eff == '0) begin
         lines_eff = LW'(1);
      end else if (lines_eff > LW'(MAX_HEIGHT)) begin
         lines_eff = LW'(MAX_HEIGHT);
      end

      col_cur  = frame_start ? '0 : col_ff;
      row_cur  = frame_start ? '0 : row_ff;
      col_next = PW'(col_cur) + PW'(1);
      row_next = LW'(row_cur) + LW'(1);
      col_wrap = (col_next >= pairs_eff);
      row_wrap = (row_next >= lines_eff);

      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : CNT_W'(row_next);
         end else begin
            col_in = COL_W'(col_next);
            row_in = row_cur;
         end
      end

      slot             = col_cur;
      tag.pair_column  = y2n_pkg::COLUMN_W'(col_cur);
      tag.row_index    = y2n_pkg::ROW_W'(row_cur);
      tag.chroma_valid = row_cur[0];
      tag.frame_last   = (col_next == pairs_eff) && (row_next == lines_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/yuyv_to_nv12_chroma_average.sv
// Top level of the YUYV 4:2:2 to NV12 4:2:0 chroma averaging block.
`default_nettype none
`include "yuyv_to_nv12_chroma_average_assert.svh"
// The block takes one YUYV word per clock and returns one result per word
// in the cycle after the transfer, sustaining one item per cycle while the
// result side keeps up. Each item does exactly one access to the chroma line
// buffer: even rows write the Cb/Cr pair at their column, odd rows read it
// and the output stage averages it with the new pair, so the line buffer's
// single read and single write port set the rate. A line of exactly one pair
// reads back the entry written by the word just before; the registered read
// sees that write, so no stall is needed. The line buffer is not cleared
// after reset; odd rows must follow an even row of the same width.
module yuyv_to_nv12_chroma_average #(
   parameter int MAX_WIDTH  = y2n_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = y2n_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // luma_first [7:0], chroma_blue [15:8], luma_second [23:16], chroma_red [31:24]
   input  wire logic [31:0] req_tdata,
   // frame_start [0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // luma_first_out [7:0], luma_second_out [15:8], blue_average [23:16],
   // red_average [31:24], pair_column [40:32], row_index [52:41], zero [55:53]
   output logic      [55:0] rsp_tdata,
   // chroma_valid [0]
   output logic      [0:0]  rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [y2n_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [y2n_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [y2n_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic             csr_pready
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int COL_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int SW = y2n_pkg::SAMPLE_W;

   logic [y2n_pkg::PAIRS_W-1:0] pairs_ff, pairs_in;
   logic [y2n_pkg::LINES_W-1:0] lines_ff, lines_in;
   y2n_pkg::reg_index_type      csr_index;
   logic                        csr_write;

   logic             accept;
   logic [COL_W-1:0] slot;
   y2n_pkg::tag_type tag;

   logic             valid_ff, valid_in;
   logic [SW-1:0]    luma_first_ff, luma_second_ff, blue_ff, red_ff;
   y2n_pkg::tag_type tag_ff;
   logic [2*SW-1:0]  stored;
   logic [SW:0]      blue_sum, red_sum;
   logic [SW-1:0]    blue_average, red_average;

   // Configuration registers.
   assign csr_index  = y2n_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      pairs_in = pairs_ff;
      lines_in = lines_ff;
      if (csr_write) begin
         case (csr_index)
            y2n_pkg::REG_PAIRS: pairs_in = csr_pwdata[y2n_pkg::PAIRS_W-1:0];
            y2n_pkg::REG_LINES: lines_in = csr_pwdata[y2n_pkg::LINES_W-1:0];
            default: ;
         endcase
      end
      case (csr_index)
         y2n_pkg::REG_PAIRS: csr_prdata = y2n_pkg::CSR_DATA_W'(pairs_ff);
         y2n_pkg::REG_LINES: csr_prdata = y2n_pkg::CSR_DATA_W'(lines_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // The output register frees up whenever its result is taken.
   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   y2n_position #(
      .LINE_DEPTH (LINE_DEPTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .frame_start (req_tuser[0]),
      .pairs_cfg   (pairs_ff),
      .lines_cfg   (lines_ff),
      .slot        (slot),
      .tag         (tag)
   );

   // Even rows store {Cr, Cb}; odd rows read the pair stored one row above.
   y2n_ram #(
      .WIDTH (2 * SW),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock (clock),
      .we    (accept && !tag.chroma_valid),
      .waddr (slot),
      .wdata ({req_tdata[31:24], req_tdata[15:8]}),
      .re    (accept && tag.chroma_valid),
      .raddr (slot),
      .rdata (stored)
   );

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_ff <= y2n_pkg::PAIRS_RESET;
         lines_ff <= y2n_pkg::LINES_RESET;
         valid_ff <= 1'b0;
      end else begin
         pairs_ff <= pairs_in;
         lines_ff <= lines_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         luma_first_ff  <= req_tdata[7:0];
         blue_ff        <= req_tdata[15:8];
         luma_second_ff <= req_tdata[23:16];
         red_ff         <= req_tdata[31:24];
         tag_ff         <= tag;
      end
   end

   // The read data stays in the RAM output register while the result waits.
   always_comb begin
      blue_sum     = {1'b0, stored[SW-1:0]} + {1'b0, blue_ff};
      red_sum      = {1'b0, stored[2*SW-1:SW]} + {1'b0, red_ff};
      blue_average = tag_ff.chroma_valid ? blue_sum[SW:1] : '0;
      red_average  = tag_ff.chroma_valid ? red_sum[SW:1] : '0;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, tag_ff.row_index, tag_ff.pair_column,
                        red_average, blue_average, luma_second_ff, luma_first_ff};
   assign rsp_tuser  = tag_ff.chroma_valid;
   assign rsp_tlast  = tag_ff.frame_last;

   `Y2N_ASSERT_SAME(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `Y2N_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_tvalid)
   `Y2N_ASSERT_SAME(a_chroma_on_odd_rows, clock, reset, rsp_tvalid, rsp_tuser[0] == rsp_tdata[41])

endmodule
`default_nettype wire
